[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, suspended while reset is asserted.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) \
        else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`endif

[rtl/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

    localparam int VALUE_W       = 32;
    localparam int PRIO_W        = 16;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

    typedef struct packed {
        logic                       opcode;
        logic signed [VALUE_W-1:0]  item_value;
        logic        [PRIO_W-1:0]   priority_req;
    } in_item_t;

    typedef struct packed {
        logic        [STATUS_W-1:0]      status;
        logic signed [VALUE_W-1:0]       removed_value;
        logic        [ENTRY_COUNT_W-1:0] entry_count;
    } result_t;

    // Broadcast to every cell for one insert transfer.
    typedef struct packed {
        logic                      ins_en;
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
    } cell_cmd_t;

    // Handed from a cell to its right neighbor.
    typedef struct packed {
        logic                      after;
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
    } cell_link_t;

endpackage

[rtl/spq_cell.sv]
`timescale 1ns / 1ps

module spq_cell
(
    input  logic                                clk,
    input  logic                                occupied,
    input  logic                                tail,
    input  spq_pkg::cell_cmd_t                  cmd,
    input  spq_pkg::cell_link_t                 left,
    output spq_pkg::cell_link_t                 right,
    output logic signed [spq_pkg::VALUE_W-1:0]  tail_value
);

    logic signed [spq_pkg::VALUE_W-1:0] value_reg;
    logic        [spq_pkg::PRIO_W-1:0]  prio_reg;
    logic signed [spq_pkg::VALUE_W-1:0] value_next;
    logic        [spq_pkg::PRIO_W-1:0]  prio_next;
    logic                               after;

    // This slot sits at or past the insertion point.
    assign after = !occupied || (prio_reg > cmd.prio);

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (cmd.ins_en && after)
        begin
            if (left.after)
            begin
                // advance the neighbor's entry one slot toward the tail
                value_next = left.value;
                prio_next  = left.prio;
            end
            else
            begin
                value_next = cmd.value;
                prio_next  = cmd.prio;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign right.after = after;
    assign right.value = value_reg;
    assign right.prio  = prio_reg;
    assign tail_value  = tail ? value_reg : '0;

endmodule

[rtl/sorted_priority_queue_core.sv]
`timescale 1ns / 1ps
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------
// command  | start, busy          | cmd    (spq_pkg::in_item_t)
// result   | done (one-cycle)     | result (spq_pkg::result_t)
//
// One command per cycle; its result shows in the cycle after the transfer.
// Every cell of the chain updates in the same cycle, so busy stays low.
// Reset clears the entry count and the result strobe; slot contents are don't-care until written.
// The receiver cannot stall: each result is valid for exactly one cycle.

`include "assert_macros.svh"

module sorted_priority_queue_core
#(
    parameter int CAPACITY = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  spq_pkg::in_item_t cmd,
    output logic              done,
    output spq_pkg::result_t  result
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 done_reg;
    logic                 done_next;
    spq_pkg::result_t     result_reg;
    spq_pkg::result_t     result_next;

    logic                 accept;
    logic                 is_empty;
    logic                 is_full;
    spq_pkg::cell_cmd_t   cell_cmd;
    spq_pkg::cell_link_t  links [CAPACITY+1];
    logic signed [spq_pkg::VALUE_W-1:0] tail_values [CAPACITY];
    logic signed [spq_pkg::VALUE_W-1:0] tail_value;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == COUNT_W'(CAPACITY));

    assign cell_cmd.ins_en = accept && (cmd.opcode == spq_pkg::OP_INSERT) && !is_full;
    assign cell_cmd.value  = cmd.item_value;
    assign cell_cmd.prio   = cmd.priority_req;

    assign links[0].after = 1'b0;
    assign links[0].value = '0;
    assign links[0].prio  = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_cell u_cell
        (
            .clk        (clk),
            .occupied   (COUNT_W'(i) < count_reg),
            .tail       (COUNT_W'(i + 1) == count_reg),
            .cmd        (cell_cmd),
            .left       (links[i]),
            .right      (links[i+1]),
            .tail_value (tail_values[i])
        );
    end

    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail_value = tail_value | tail_values[i];
        end
    end

    always_comb
    begin
        count_next                = count_reg;
        result_next.status        = spq_pkg::ST_INSERTED;
        result_next.removed_value = '0;
        if (cmd.opcode == spq_pkg::OP_INSERT)
        begin
            if (is_full)
            begin
                result_next.status = spq_pkg::ST_OVERFLOW;
            end
            else
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
        else if (is_empty)
        begin
            result_next.status = spq_pkg::ST_UNDERFLOW;
        end
        else
        begin
            result_next.status        = spq_pkg::ST_REMOVED;
            result_next.removed_value = tail_value;
            count_next                = count_reg - COUNT_W'(1);
        end
        result_next.entry_count = spq_pkg::ENTRY_COUNT_W'(count_next);
        if (!accept)
        begin
            count_next = count_reg;
        end
        done_next = accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, !rst_n || count_reg <= COUNT_W'(CAPACITY), "count past capacity")
    `ASSERT_CLK(a_done_follows, clk, rst_n, accept |=> done, "transfer without result")
    `ASSERT_CLK(a_overflow_full, clk, rst_n,
        done && result.status == spq_pkg::ST_OVERFLOW |-> is_full, "overflow when not full")
    `ASSERT_CLK(a_underflow_empty, clk, rst_n,
        done && result.status == spq_pkg::ST_UNDERFLOW |-> is_empty, "underflow when not empty")
    `ASSERT_CLK(a_count_step, clk, rst_n,
        !$past(accept) |-> $stable(count_reg), "count moved without transfer")

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_OPS  = 680;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    in_item_t cmd;
    logic     done;
    result_t  result;

    sorted_priority_queue_core #(.CAPACITY(CAPACITY)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // Shadow copy of the queue: slot 0 is the front, lowest priority value.
    logic signed [VALUE_W-1:0] shadow_values [CAPACITY];
    logic        [PRIO_W-1:0]  shadow_prios  [CAPACITY];
    int                        shadow_count;

    result_t pending_results [$];
    int      error_count;
    int      stall_cycles;
    bit      back_to_back;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic result_t predict_queue_op(input in_item_t it);
        result_t r;
        int      pos;
        r.status        = ST_INSERTED;
        r.removed_value = '0;
        if (it.opcode == OP_INSERT)
        begin
            if (shadow_count >= CAPACITY)
                r.status = ST_OVERFLOW;
            else
            begin
                // land after every entry with an equal or lower key
                pos = 0;
                while (pos < shadow_count && shadow_prios[pos] <= it.priority_req)
                    pos++;
                for (int k = shadow_count; k > pos; k--)
                begin
                    shadow_values[k] = shadow_values[k-1];
                    shadow_prios[k]  = shadow_prios[k-1];
                end
                shadow_values[pos] = it.item_value;
                shadow_prios[pos]  = it.priority_req;
                shadow_count++;
            end
        end
        else if (shadow_count == 0)
            r.status = ST_UNDERFLOW;
        else
        begin
            shadow_count--;
            r.status        = ST_REMOVED;
            r.removed_value = shadow_values[shadow_count];
        end
        r.entry_count = ENTRY_COUNT_W'(shadow_count);
        return r;
    endfunction

    // Check the result of the previous transfer first, then predict this one.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with nothing pending: status %0d value %h count %0d",
                             $time, result.status, result.removed_value, result.entry_count);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, result.status);
                        error_count++;
                    end
                    if (result.removed_value !== want.removed_value)
                    begin
                        $display("%0t: removed_value mismatch: expected %h actual %h",
                                 $time, want.removed_value, result.removed_value);
                        error_count++;
                    end
                    if (result.entry_count !== want.entry_count)
                    begin
                        $display("%0t: entry_count mismatch: expected %0d actual %0d",
                                 $time, want.entry_count, result.entry_count);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
                pending_results.push_back(predict_queue_op(cmd));
        end
        if ((rst_n && start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("** sorted_priority_queue_core: FAILED **");
        $finish;
    end

    function automatic in_item_t make_item(input logic op, input logic [VALUE_W-1:0] val,
                                           input logic [PRIO_W-1:0] prio);
        in_item_t it;
        it.opcode       = op;
        it.item_value   = val;
        it.priority_req = prio;
        return it;
    endfunction

    task automatic send_cmd(input in_item_t it);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 18);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= it;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Hold off the sender until every outstanding result is back.
    task automatic wait_for_results;
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_remove_empty;
        send_cmd(make_item(OP_REMOVE, 32'h8000_0000, 16'hFFFF));
    endtask

    task automatic test_fill_to_overflow;
        logic [VALUE_W-1:0] fill_vals [16] = '{
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
            32'h0000_0001, 32'h0000_0005, 32'hFFFF_FFFE, 32'h5555_5555,
            32'hAAAA_AAAA, 32'h0000_0007, 32'h0000_0008, 32'h0000_0009,
            32'h0000_000A, 32'h0000_000B, 32'h0000_000C, 32'h0000_000D};
        logic [PRIO_W-1:0]  fill_prios [16] = '{
            16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF,
            16'h0000, 16'h8000, 16'h7FFF, 16'h5555,
            16'hAAAA, 16'hFFFF, 16'h0000, 16'h8000,
            16'h0001, 16'hFFFE, 16'hFFFF, 16'h8000};
        for (int i = 0; i < 16; i++)
            send_cmd(make_item(OP_INSERT, fill_vals[i], fill_prios[i]));
        send_cmd(make_item(OP_INSERT, 32'h7FFF_FFFF, 16'h0000));
        // tail among equal keys must come out latest arrival first
        for (int i = 0; i < 3; i++)
            send_cmd(make_item(OP_REMOVE, $urandom, PRIO_W'($urandom_range(0, 65535))));
    endtask

    function automatic logic [PRIO_W-1:0] draw_priority;
        case ($urandom_range(0, 3))
            0:       return PRIO_W'($urandom_range(0, 3));
            1:       return PRIO_W'($urandom_range(0, 65535));
            2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return PRIO_W'(16'hFFFC + $urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] draw_value;
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random_traffic;
        int  sent;
        int  burst;
        int  burst_len;
        int  insert_pct;
        logic op;
        sent  = 0;
        burst = 0;
        while (sent < RANDOM_OPS)
        begin
            burst_len    = $urandom_range(10, 40);
            back_to_back = ($urandom_range(0, 3) == 0);
            // bias each burst toward filling, draining or a balanced mix
            case ($urandom_range(0, 2))
                0:       insert_pct = 80;
                1:       insert_pct = 20;
                default: insert_pct = 50;
            endcase
            for (int i = 0; i < burst_len; i++)
            begin
                op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
                send_cmd(make_item(op, draw_value(), draw_priority()));
            end
            sent += burst_len;
            if (burst == 0 || $urandom_range(0, 3) == 0)
                wait_for_results();
            burst++;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        error_count  = 0;
        stall_cycles = 0;
        shadow_count = 0;
        back_to_back = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_remove_empty();
        test_fill_to_overflow();
        test_random_traffic();

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("** sorted_priority_queue_core: PASSED **");
        else
            $display("** sorted_priority_queue_core: FAILED **");
        $finish;
    end

endmodule
